>>> rtl/core/sli_pkg.sv
`timescale 1ns / 1ps

package sli_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned OCNT_W   = 5;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } sli_action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } sli_status_e;

  typedef struct packed {
    logic                    action;
    logic signed [VAL_W-1:0] value;
  } sli_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] head_value;
    logic                    head_valid;
    logic [OCNT_W-1:0]       count;
    logic [1:0]              status;
  } sli_out_t;

  // broadcast to every cell
  typedef struct packed {
    logic                    ins_en;
    logic                    del_en;
    logic signed [VAL_W-1:0] key;
  } sli_cmd_t;

endpackage

>>> rtl/core/sli_cell.sv
`timescale 1ns / 1ps

module sli_cell (
  input  logic                            clk_i,
  input  sli_pkg::sli_cmd_t               cmd_i,
  input  logic                            occ_i,
  input  logic                            left_keep_i,
  input  logic signed [sli_pkg::VAL_W-1:0] left_value_i,
  input  logic signed [sli_pkg::VAL_W-1:0] right_value_i,
  input  logic                            found_i,
  output logic                            keep_o,
  output logic                            found_o,
  output logic signed [sli_pkg::VAL_W-1:0] value_o,
  output logic signed [sli_pkg::VAL_W-1:0] next_o
);
  import sli_pkg::*;

  logic signed [VAL_W-1:0] value_q;
  logic signed [VAL_W-1:0] value_d;
  logic                    match;

  assign keep_o  = occ_i && (value_q < cmd_i.key);
  assign match   = occ_i && (value_q == cmd_i.key);
  assign found_o = found_i || match;
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (cmd_i.ins_en) begin
      if (keep_o) begin
        value_d = value_q;
      end else if (left_keep_i) begin
        value_d = cmd_i.key;
      end else begin
        value_d = left_value_i;
      end
    end else if (cmd_i.del_en) begin
      if (found_o) begin
        value_d = right_value_i;
      end
    end
  end

  assign next_o = value_d;

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

>>> rtl/core/sorted_list_insert_delete.sv
`timescale 1ns / 1ps

// Sorted list of up to CAPACITY signed 32-bit keys held in a row of cells, smallest first.
// Each transaction inserts a key ahead of existing equals (action 0) or removes the first
// equal key (action 1) and returns the new head, a non-empty flag, the count and a status
// (full on insert into a full list, not found on a failed delete). All cells compare
// against the key in parallel and shift by one place in the same cycle, so one transaction
// is taken per clock while the input is not stalled; its result is in the output register
// in the next cycle, and a new one is taken while that register is empty or being drained.
module sorted_list_insert_delete (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sli_pkg::sli_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sli_pkg::sli_out_t out_data_o
);
  import sli_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  sli_out_t         out_data_q, out_data_d;
  logic             accept;
  logic             full;
  logic             is_ins;
  sli_cmd_t         cmd;

  logic                    keep  [CAPACITY];
  logic                    found [CAPACITY];
  logic                    occ   [CAPACITY];
  logic signed [VAL_W-1:0] cur   [CAPACITY];
  logic signed [VAL_W-1:0] nxt   [CAPACITY];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = count_q == CNT_W'(CAPACITY);
  assign is_ins     = in_data_i.action == ACT_INSERT;

  assign cmd.ins_en = accept && is_ins && !full;
  assign cmd.del_en = accept && !is_ins;
  assign cmd.key    = in_data_i.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = CNT_W'(i) < count_q;
    sli_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (occ[i]),
      .left_keep_i  ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
      .left_value_i (cur[(i == 0) ? 0 : i - 1]),
      .right_value_i(cur[(i == CAPACITY - 1) ? i : i + 1]),
      .found_i      ((i == 0) ? 1'b0 : found[(i == 0) ? 0 : i - 1]),
      .keep_o       (keep[i]),
      .found_o      (found[i]),
      .value_o      (cur[i]),
      .next_o       (nxt[i])
    );
  end

  always_comb begin
    count_d    = count_q;
    out_data_d = out_data_q;
    if (accept) begin
      out_data_d.status = ST_OK;
      if (is_ins) begin
        if (full) begin
          out_data_d.status = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end else begin
        if (found[CAPACITY-1]) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          out_data_d.status = ST_NOT_FOUND;
        end
      end
      out_data_d.head_valid = count_d != '0;
      out_data_d.head_value = (count_d != '0) ? nxt[0] : '0;
      out_data_d.count      = OCNT_W'(count_d);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (accept) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/core/sli_checker.sv
`timescale 1ns / 1ps

module sli_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input sli_pkg::sli_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input sli_pkg::sli_out_t out_data_o
);
  import sli_pkg::*;

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_head_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.head_valid == (out_data_o.count != '0))
    else $error("head flag disagrees with count");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.head_valid |-> out_data_o.head_value == '0)
    else $error("empty list with nonzero head");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FULL |-> out_data_o.count == OCNT_W'(CAPACITY))
    else $error("full status with wrong count");

endmodule

bind sorted_list_insert_delete sli_checker u_sli_checker (.*);
